// ===== rtl/core/hmf_pkg.sv =====
// shared types, constants and keyword table of the http message framer
package hmf_pkg;

    // width of the internal length and body counters
    localparam int LENGTH_BITS  = 32;
    // width of the reported content length
    localparam int OUT_BITS     = 32;
    localparam int LEN_EXT_BITS = LENGTH_BITS + OUT_BITS;
    // product width for length * 10 + digit
    localparam int PROD_BITS    = LENGTH_BITS + 4;

    localparam int KW_LEN      = 15;
    localparam int KW_IDX_BITS = 4;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_KW_C  = 8'h43;

    typedef logic [LENGTH_BITS-1:0] t_length;
    localparam t_length LENGTH_MAX = '1;

    // message phase
    typedef enum logic [1:0] {
        PH_HEADERS = 2'd0,
        PH_BODY    = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    // progress of the content length value parse
    typedef enum logic [1:0] {
        VP_SEARCH = 2'd0,
        VP_SPACES = 2'd1,
        VP_DIGITS = 2'd2,
        VP_DONE   = 2'd3
    } t_value_phase;

    // one request byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_new;
    } t_in_item;

    // one result
    typedef struct packed {
        logic                status;
        logic                byte_is_body;
        logic [OUT_BITS-1:0] msg_length;
        logic                length_overflow;
    } t_result;

    // characters of "Content-Length:" by position, nul past the end
    function automatic logic [7:0] keyword_char(input logic [KW_IDX_BITS-1:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                4'd0:    ch = 8'h43; // C
                4'd1:    ch = 8'h6F; // o
                4'd2:    ch = 8'h6E; // n
                4'd3:    ch = 8'h74; // t
                4'd4:    ch = 8'h65; // e
                4'd5:    ch = 8'h6E; // n
                4'd6:    ch = 8'h74; // t
                4'd7:    ch = 8'h2D; // -
                4'd8:    ch = 8'h4C; // L
                4'd9:    ch = 8'h65; // e
                4'd10:   ch = 8'h6E; // n
                4'd11:   ch = 8'h67; // g
                4'd12:   ch = 8'h74; // t
                4'd13:   ch = 8'h68; // h
                4'd14:   ch = 8'h3A; // :
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

// ===== rtl/core/hmf_if.sv =====
// request and result channel interfaces of the http message framer
interface hmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_new;

    modport source (output valid, output data_byte, output start_new, input ready);
    modport sink   (input valid, input data_byte, input start_new, output ready);
endinterface

interface hmf_out_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic                         byte_is_body;
    logic [hmf_pkg::OUT_BITS-1:0] msg_length;
    logic                         length_overflow;

    modport source (output valid, output status, output byte_is_body,
                    output msg_length, output length_overflow, input ready);
    modport sink   (input valid, input status, input byte_is_body,
                    input msg_length, input length_overflow, output ready);
endinterface

// ===== rtl/core/hmf_in_reg.sv =====
// input register stage of the http message framer
module hmf_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hmf_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_ready,
    output logic              o_valid,
    output hmf_pkg::t_in_item o_item
);
    logic              r_valid;
    logic              n_valid;
    hmf_pkg::t_in_item r_item;
    logic              accept;

    // take a new request when empty or when the held one moves on
    assign o_ready = !r_valid || i_advance;
    assign accept  = i_valid && o_ready;
    assign n_valid = accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== rtl/core/hmf_parser.sv =====
// header matchers, length parse and body counter, one byte per cycle when the byte advances
module hmf_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  hmf_pkg::t_in_item i_item,
    output hmf_pkg::t_result  o_result
);
    hmf_pkg::t_phase       r_phase, c_phase, n_phase;
    logic [1:0]            r_term, c_term, n_term;
    logic [hmf_pkg::KW_IDX_BITS-1:0] r_kw, c_kw, n_kw;
    hmf_pkg::t_value_phase r_vp, c_vp, n_vp;
    hmf_pkg::t_length      r_len, c_len, n_len;
    hmf_pkg::t_length      r_body, c_body, n_body;
    logic                  r_ovf, c_ovf, n_ovf;

    logic [7:0]                        b;
    logic                              is_digit;
    logic [3:0]                        digit;
    logic [7:0]                        digit_full;
    logic [hmf_pkg::PROD_BITS-1:0]     len_ext;
    logic [hmf_pkg::PROD_BITS-1:0]     prod;
    logic                              do_digit;
    logic                              is_body;
    logic [hmf_pkg::LEN_EXT_BITS-1:0]  len_wide;

    assign b          = i_item.data_byte;
    assign is_digit   = (b >= hmf_pkg::CHAR_ZERO) && (b <= hmf_pkg::CHAR_NINE);
    assign digit_full = b - hmf_pkg::CHAR_ZERO;
    assign digit      = digit_full[3:0];

    // state as seen by this byte: start_new clears it first
    always_comb begin
        if (i_item.start_new) begin
            c_phase = hmf_pkg::PH_HEADERS;
            c_term  = '0;
            c_kw    = '0;
            c_vp    = hmf_pkg::VP_SEARCH;
            c_len   = '0;
            c_body  = '0;
            c_ovf   = 1'b0;
        end else begin
            c_phase = r_phase;
            c_term  = r_term;
            c_kw    = r_kw;
            c_vp    = r_vp;
            c_len   = r_len;
            c_body  = r_body;
            c_ovf   = r_ovf;
        end
    end

    // length * 10 + digit, saturation when it passes the counter range
    assign len_ext = {4'b0, c_len};
    assign prod    = (len_ext << 3) + (len_ext << 1)
                   + {{(hmf_pkg::PROD_BITS-4){1'b0}}, digit};

    // next state
    always_comb begin
        n_phase  = c_phase;
        n_term   = c_term;
        n_kw     = c_kw;
        n_vp     = c_vp;
        n_len    = c_len;
        n_body   = c_body;
        n_ovf    = c_ovf;
        do_digit = 1'b0;
        is_body  = 1'b0;

        unique case (c_phase)
            hmf_pkg::PH_HEADERS: begin
                // keyword search and value parse
                unique case (c_vp)
                    hmf_pkg::VP_SEARCH: begin
                        if (b == hmf_pkg::keyword_char(c_kw)) begin
                            if (c_kw == 4'(hmf_pkg::KW_LEN - 1)) begin
                                n_kw = '0;
                                n_vp = hmf_pkg::VP_SPACES;
                            end else begin
                                n_kw = c_kw + 1'b1;
                            end
                        end else begin
                            n_kw = (b == hmf_pkg::CHAR_KW_C) ? 4'd1 : 4'd0;
                        end
                    end
                    hmf_pkg::VP_SPACES: begin
                        if (is_digit) begin
                            do_digit = 1'b1;
                            n_vp     = hmf_pkg::VP_DIGITS;
                        end else if (b != hmf_pkg::CHAR_SPACE) begin
                            n_vp = hmf_pkg::VP_DONE;
                        end
                    end
                    hmf_pkg::VP_DIGITS: begin
                        if (is_digit) begin
                            do_digit = 1'b1;
                        end else begin
                            n_vp = hmf_pkg::VP_DONE;
                        end
                    end
                    default: begin
                        n_vp = c_vp;
                    end
                endcase

                if (do_digit) begin
                    if (prod > {4'b0, hmf_pkg::LENGTH_MAX}) begin
                        n_len = hmf_pkg::LENGTH_MAX;
                        n_ovf = 1'b1;
                    end else begin
                        n_len = prod[hmf_pkg::LENGTH_BITS-1:0];
                    end
                end

                // header terminator cr lf cr lf
                if (c_term == 2'd3 && b == hmf_pkg::CHAR_LF) begin
                    n_term = 2'd0;
                    if (n_vp == hmf_pkg::VP_SEARCH || n_len == '0) begin
                        n_phase = hmf_pkg::PH_DONE;
                    end else begin
                        n_phase = hmf_pkg::PH_BODY;
                        n_body  = '0;
                    end
                end else if ((c_term == 2'd0 || c_term == 2'd2) && b == hmf_pkg::CHAR_CR) begin
                    n_term = c_term + 2'd1;
                end else if (c_term == 2'd1 && b == hmf_pkg::CHAR_LF) begin
                    n_term = 2'd2;
                end else begin
                    n_term = (b == hmf_pkg::CHAR_CR) ? 2'd1 : 2'd0;
                end
            end
            hmf_pkg::PH_BODY: begin
                // saturating body count
                is_body = 1'b1;
                if (c_body != hmf_pkg::LENGTH_MAX) begin
                    n_body = c_body + 1'b1;
                end
                if (n_body >= c_len) begin
                    n_phase = hmf_pkg::PH_DONE;
                end
            end
            default: begin
                n_phase = c_phase;
            end
        endcase
    end

    // result of this byte
    assign len_wide = {{hmf_pkg::OUT_BITS{1'b0}}, n_len};
    always_comb begin
        o_result.status = !(n_phase == hmf_pkg::PH_HEADERS || n_phase == hmf_pkg::PH_BODY);
        o_result.byte_is_body = is_body;
        if (len_wide[hmf_pkg::LEN_EXT_BITS-1:hmf_pkg::OUT_BITS] != '0) begin
            o_result.msg_length = '1;
        end else begin
            o_result.msg_length = len_wide[hmf_pkg::OUT_BITS-1:0];
        end
        o_result.length_overflow = n_ovf;
    end

    // state registers, updated when the byte moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hmf_pkg::PH_HEADERS;
            r_term  <= '0;
            r_kw    <= '0;
            r_vp    <= hmf_pkg::VP_SEARCH;
            r_len   <= '0;
            r_body  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_term  <= n_term;
            r_kw    <= n_kw;
            r_vp    <= n_vp;
            r_len   <= n_len;
            r_body  <= n_body;
            r_ovf   <= n_ovf;
        end
    end
endmodule

// ===== rtl/core/hmf_out_reg.sv =====
// result register stage of the http message framer
module hmf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hmf_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_space,
    output logic             o_valid,
    output hmf_pkg::t_result o_result
);
    logic             r_valid;
    logic             n_valid;
    hmf_pkg::t_result r_result;
    logic             load;

    // room when empty or when the held result is taken this cycle
    assign o_space = !r_valid || i_ready;
    assign load    = i_valid && o_space;
    assign n_valid = load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

// ===== rtl/core/http_message_framer.sv =====
// Top level of the http message framer: Content-Length message framing over a byte
// stream. Each request carries one byte and a start_new flag that clears the parser
// before that byte. Every byte yields one result: status (message complete after this
// byte), whether the byte counted as body, the content length parsed so far
// (saturated to 32 bits) and the length overflow flag. A byte is accepted every cycle
// while the output is not stalled; the input register holds it and the result register
// takes its result. The one-byte state update in the parser stage sets the rate, one byte
// per clock. While the output stalls, the two registers hold up to two bytes in flight.
module http_message_framer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hmf_in_if.sink           i_in,
    hmf_out_if.source        o_out
);
    hmf_pkg::t_in_item in_item;
    hmf_pkg::t_in_item held_item;
    hmf_pkg::t_result  parse_result;
    hmf_pkg::t_result  out_result;
    logic              held_valid;
    logic              out_space;
    logic              advance;

    assign in_item.data_byte = i_in.data_byte;
    assign in_item.start_new = i_in.start_new;

    // a held byte moves on when the result register has room
    assign advance = held_valid && out_space;

    hmf_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    hmf_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (held_item),
        .o_result  (parse_result)
    );

    hmf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .i_result (parse_result),
        .i_ready  (o_out.ready),
        .o_space  (out_space),
        .o_valid  (o_out.valid),
        .o_result (out_result)
    );

    assign o_out.status          = out_result.status;
    assign o_out.byte_is_body    = out_result.byte_is_body;
    assign o_out.msg_length      = out_result.msg_length;
    assign o_out.length_overflow = out_result.length_overflow;
endmodule

// ===== rtl/core/hmf_checker.sv =====
// port-level checks of the http message framer and their binding
module hmf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_status,
    input logic                         i_byte_is_body,
    input logic [hmf_pkg::OUT_BITS-1:0] i_msg_length,
    input logic                         i_length_overflow
);
    // no result is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds its contents
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_status) && $stable(i_byte_is_body)
            && $stable(i_msg_length) && $stable(i_length_overflow))
        else $error("stalled result changed");

    // body bytes only exist for a nonzero content length
    a_body_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_byte_is_body |-> i_msg_length != '0)
        else $error("body byte with zero content length");

    // an overflowed length is never reported as zero
    a_overflow_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_length_overflow |-> i_msg_length != '0)
        else $error("overflow with zero content length");
endmodule

bind http_message_framer hmf_checker u_hmf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_status          (o_out.status),
    .i_byte_is_body    (o_out.byte_is_body),
    .i_msg_length      (o_out.msg_length),
    .i_length_overflow (o_out.length_overflow)
);
